@@ sv/thwc_pkg.sv @@
// Types, constants, microcode table and classifier function of the climate window classifier.
`default_nettype none
package thwc_pkg;

   // Request and response payloads.
   typedef struct packed {
      logic        opcode;
      logic [13:0] sample_first;
      logic [13:0] sample_second;
      logic [13:0] sample_third;
   } thwc_req_type;

   typedef struct packed {
      logic signed [14:0] measured_value;
      logic [1:0]         class_plant0;
      logic [1:0]         class_plant1;
      logic               changed_plant0;
      logic               changed_plant1;
   } thwc_rsp_type;

   // Opcodes of a request.
   localparam logic OP_TEMP  = 1'b0;
   localparam logic OP_HUMID = 1'b1;

   // Configuration register indexes.
   localparam logic [2:0] CSR_TEMP_LOW0  = 3'd0;
   localparam logic [2:0] CSR_TEMP_LOW1  = 3'd1;
   localparam logic [2:0] CSR_TEMP_HIGH0 = 3'd2;
   localparam logic [2:0] CSR_TEMP_HIGH1 = 3'd3;
   localparam logic [2:0] CSR_HUMID_LOW0  = 3'd4;
   localparam logic [2:0] CSR_HUMID_LOW1  = 3'd5;
   localparam logic [2:0] CSR_HUMID_HIGH0 = 3'd6;
   localparam logic [2:0] CSR_HUMID_HIGH1 = 3'd7;

   // Reset values.
   localparam logic signed [14:0] TEMP_LOW_RESET   = 15'sd1500;
   localparam logic signed [14:0] TEMP_HIGH_RESET  = 15'sd3000;
   localparam logic [11:0]        HUMID_LOW_RESET  = 12'd1000;
   localparam logic [11:0]        HUMID_HIGH_RESET = 12'd3000;
   localparam logic signed [14:0] LAST_TEMP_RESET  = 15'sd2000;

   localparam logic signed [16:0] TEMP_HYSTERESIS  = 17'sd100;
   localparam logic signed [16:0] HUMID_HYSTERESIS = 17'sd50;

   // Arithmetic constants; humidity coefficients are scaled by 2^24.
   localparam logic signed [26:0] RECIP3      = 27'sd43691;   // ceil(2^17 / 3)
   localparam int                 RECIP3_SHIFT = 17;
   localparam logic signed [14:0] TEMP_OFFSET = 15'sd3960;
   localparam logic signed [14:0] TEMP_REF    = 15'sd2500;
   localparam logic signed [28:0] HK_C1       = 29'sd167772;
   localparam logic signed [26:0] HK_C2       = 27'sd1342;
   localparam logic signed [47:0] HK_C0       = 48'sd3433960571;
   localparam logic signed [26:0] HK_C3       = 27'sd61572383;
   localparam logic signed [26:0] HK_C4       = 27'sd2677;
   localparam logic signed [47:0] TRUNC_BIAS  = 48'sd16777215;
   localparam logic signed [23:0] HUMID_MAX   = 24'sd10000;

   // Classifier zones.
   typedef enum logic [1:0] {
      ZONE_OK   = 2'd0,
      ZONE_LOW  = 2'd1,
      ZONE_HIGH = 2'd2
   } zone_type;

   // Sequencer state.
   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // Microcode fields.
   typedef enum logic [1:0] {
      A_SUM,
      A_AVG,
      A_TMP
   } opa_sel_type;

   typedef enum logic [2:0] {
      B_RECIP3,
      B_C2,
      B_C3,
      B_C4,
      B_TDIFF,
      B_AVG
   } opb_sel_type;

   typedef enum logic [1:0] {
      TMP_HOLD,
      TMP_PROD_C1,
      TMP_PROD
   } tmp_op_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_PROD_MC0,
      ACC_ADD,
      ACC_SUB,
      ACC_TRUNC
   } acc_op_type;

   typedef enum logic [1:0] {
      FIN_NONE,
      FIN_TEMP,
      FIN_HUMID
   } fin_type;

   localparam int STEP_W = 4;

   typedef struct packed {
      logic              mul_en;
      opa_sel_type       a_sel;
      opb_sel_type       b_sel;
      tmp_op_type        tmp_op;
      acc_op_type        acc_op;
      logic              avg_load;
      logic              br_temp;
      logic [STEP_W-1:0] br_target;
      fin_type           fin;
   } thwc_uop_type;

   localparam logic [STEP_W-1:0] STEP_TEMP_FIN = 4'd11;

   // Microcode program. Temperature requests leave after the average.
   function automatic thwc_uop_type thwc_urom(logic [STEP_W-1:0] step);
      thwc_uop_type u;
      u.mul_en    = 1'b0;
      u.a_sel     = A_AVG;
      u.b_sel     = B_AVG;
      u.tmp_op    = TMP_HOLD;
      u.acc_op    = ACC_HOLD;
      u.avg_load  = 1'b0;
      u.br_temp   = 1'b0;
      u.br_target = STEP_TEMP_FIN;
      u.fin       = FIN_NONE;
      unique case (step)
         4'd0: begin
            u.mul_en = 1'b1; u.a_sel = A_SUM; u.b_sel = B_RECIP3;
         end
         4'd1: begin
            u.avg_load = 1'b1; u.br_temp = 1'b1;
         end
         4'd2: begin
            u.mul_en = 1'b1; u.a_sel = A_AVG; u.b_sel = B_C2;
         end
         4'd3: begin
            u.tmp_op = TMP_PROD_C1;
            u.mul_en = 1'b1; u.a_sel = A_AVG; u.b_sel = B_C3;
         end
         4'd4: begin
            u.acc_op = ACC_PROD_MC0;
            u.mul_en = 1'b1; u.a_sel = A_TMP; u.b_sel = B_TDIFF;
         end
         4'd5: begin
            u.acc_op = ACC_ADD;
            u.mul_en = 1'b1; u.a_sel = A_AVG; u.b_sel = B_AVG;
         end
         4'd6: begin
            u.tmp_op = TMP_PROD;
         end
         4'd7: begin
            u.mul_en = 1'b1; u.a_sel = A_TMP; u.b_sel = B_C4;
         end
         4'd8: begin
            u.acc_op = ACC_SUB;
         end
         4'd9: begin
            u.acc_op = ACC_TRUNC;
         end
         4'd10: begin
            u.fin = FIN_HUMID;
         end
         4'd11: begin
            u.fin = FIN_TEMP;
         end
         default: begin
            u.fin = FIN_NONE;
         end
      endcase
      return u;
   endfunction

   // Low/ok/high classifier with hysteresis on the return to ok.
   function automatic zone_type thwc_classify(zone_type cls, logic signed [16:0] v,
                                              logic signed [16:0] lo,
                                              logic signed [16:0] hi,
                                              logic signed [16:0] h);
      zone_type nxt;
      nxt = cls;
      if (cls != ZONE_LOW && v < lo) begin
         nxt = ZONE_LOW;
      end else if (cls != ZONE_HIGH && v > hi) begin
         nxt = ZONE_HIGH;
      end else if (cls != ZONE_OK && v <= hi - h && v >= lo + h) begin
         nxt = ZONE_OK;
      end
      return nxt;
   endfunction

endpackage
`default_nettype wire

@@ sv/temp_humidity_window_classifier.sv @@
// Top level of the climate window classifier: microcoded sequencer and datapath.
`default_nettype none
//
//   Channel   Direction   Handshake              Payload
//   req_      in          req_valid/req_ready    thwc_req_type (opcode, three samples)
//   rsp_      out         rsp_valid/rsp_ready    thwc_rsp_type (value, classes, changes)
//   csr_      in          csr_we (no wait)       csr_index (3 bits), csr_wdata (15 bits)
//
// A temperature request runs the averaging steps and then branches to the temperature final
// step, and a humidity request runs every step up to its own final step, one microcode step
// per cycle on the single shared multiplier unless a final step waits for the response register.
// Reset is synchronous and restores all thresholds, the stored temperature and the
// zones. A new request is taken as soon as the sequencer is idle, even while the
// previous response waits; only the final step waits for the response register.
//
module temp_humidity_window_classifier (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  thwc_pkg::thwc_req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output thwc_pkg::thwc_rsp_type rsp_data,
   input  wire                    csr_we,
   input  wire  [2:0]             csr_index,
   input  wire  [14:0]            csr_wdata
);

   // Sequencer state.
   thwc_pkg::seq_state_type           state_ff, state_in;
   logic [thwc_pkg::STEP_W-1:0]       step_ff, step_in;
   thwc_pkg::thwc_uop_type            uop;
   logic                              fin_ok;
   logic                              advance;

   // Request holding registers.
   logic                              opcode_ff, opcode_in;
   logic [15:0]                       sum_ff, sum_in;

   // Datapath registers.
   logic [13:0]                       avg_ff, avg_in;
   logic signed [47:0]                prod_ff, prod_in;
   logic signed [28:0]                tmp_ff, tmp_in;
   logic signed [47:0]                acc_ff, acc_in;
   logic signed [28:0]                mul_a;
   logic signed [26:0]                mul_b;
   logic signed [55:0]                mul_full;
   logic signed [14:0]                tdiff;

   // Architectural state.
   logic signed [14:0]                last_temp_ff, last_temp_in;
   thwc_pkg::zone_type                temp_zone_ff [2];
   thwc_pkg::zone_type                temp_zone_in [2];
   thwc_pkg::zone_type                humid_zone_ff [2];
   thwc_pkg::zone_type                humid_zone_in [2];

   // Thresholds.
   logic signed [14:0]                temp_low_ff [2];
   logic signed [14:0]                temp_low_in [2];
   logic signed [14:0]                temp_high_ff [2];
   logic signed [14:0]                temp_high_in [2];
   logic [11:0]                       humid_low_ff [2];
   logic [11:0]                       humid_low_in [2];
   logic [11:0]                       humid_high_ff [2];
   logic [11:0]                       humid_high_in [2];

   // Response register.
   logic                              rsp_valid_ff, rsp_valid_in;
   thwc_pkg::thwc_rsp_type            rsp_data_ff, rsp_data_in;

   // Final values.
   logic signed [14:0]                temp_value;
   logic signed [23:0]                quot;
   logic signed [14:0]                humid_value;
   thwc_pkg::zone_type                new_zone [2];
   logic [1:0]                        zone_changed;

   assign req_ready = (state_ff == thwc_pkg::SEQ_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign uop = thwc_pkg::thwc_urom(step_ff);

   // A finishing step must not overwrite a response that has not been taken yet.
   assign fin_ok  = (uop.fin == thwc_pkg::FIN_NONE) || !rsp_valid_ff || rsp_ready;
   assign advance = (state_ff == thwc_pkg::SEQ_RUN) && fin_ok;

   // Sequencer: next state, step counter and request capture.
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      opcode_in = opcode_ff;
      sum_in    = sum_ff;
      unique case (state_ff)
         thwc_pkg::SEQ_IDLE: begin
            if (req_valid) begin
               state_in  = thwc_pkg::SEQ_RUN;
               step_in   = '0;
               opcode_in = req_data.opcode;
               sum_in    = {2'b00, req_data.sample_first} + {2'b00, req_data.sample_second}
                         + {2'b00, req_data.sample_third};
            end
         end
         thwc_pkg::SEQ_RUN: begin
            if (advance) begin
               if (uop.fin != thwc_pkg::FIN_NONE) begin
                  state_in = thwc_pkg::SEQ_IDLE;
               end else if (uop.br_temp && opcode_ff == thwc_pkg::OP_TEMP) begin
                  step_in = uop.br_target;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = thwc_pkg::SEQ_IDLE;
         end
      endcase
   end

   // Shared multiplier with operand selection from the control word.
   assign tdiff = last_temp_ff - thwc_pkg::TEMP_REF;

   always_comb begin
      unique case (uop.a_sel)
         thwc_pkg::A_SUM: mul_a = {13'b0, sum_ff};
         thwc_pkg::A_AVG: mul_a = {15'b0, avg_ff};
         thwc_pkg::A_TMP: mul_a = tmp_ff;
         default:         mul_a = '0;
      endcase
      unique case (uop.b_sel)
         thwc_pkg::B_RECIP3: mul_b = thwc_pkg::RECIP3;
         thwc_pkg::B_C2:     mul_b = thwc_pkg::HK_C2;
         thwc_pkg::B_C3:     mul_b = thwc_pkg::HK_C3;
         thwc_pkg::B_C4:     mul_b = thwc_pkg::HK_C4;
         thwc_pkg::B_TDIFF:  mul_b = {{12{tdiff[14]}}, tdiff};
         thwc_pkg::B_AVG:    mul_b = {13'b0, avg_ff};
         default:            mul_b = '0;
      endcase
   end

   assign mul_full = mul_a * mul_b;

   // Datapath updates.
   always_comb begin
      prod_in = prod_ff;
      tmp_in  = tmp_ff;
      acc_in  = acc_ff;
      avg_in  = avg_ff;
      if (advance) begin
         if (uop.mul_en) begin
            prod_in = mul_full[47:0];
         end
         if (uop.avg_load) begin
            // The reciprocal product is exact for any 16-bit sum.
            avg_in = prod_ff[thwc_pkg::RECIP3_SHIFT +: 14];
         end
         unique case (uop.tmp_op)
            thwc_pkg::TMP_HOLD:    tmp_in = tmp_ff;
            thwc_pkg::TMP_PROD_C1: tmp_in = prod_ff[28:0] + thwc_pkg::HK_C1;
            thwc_pkg::TMP_PROD:    tmp_in = prod_ff[28:0];
            default:               tmp_in = tmp_ff;
         endcase
         unique case (uop.acc_op)
            thwc_pkg::ACC_HOLD:     acc_in = acc_ff;
            thwc_pkg::ACC_PROD_MC0: acc_in = prod_ff - thwc_pkg::HK_C0;
            thwc_pkg::ACC_ADD:      acc_in = acc_ff + prod_ff;
            thwc_pkg::ACC_SUB:      acc_in = acc_ff - prod_ff;
            // Bias a negative sum so the shift below truncates toward zero.
            thwc_pkg::ACC_TRUNC:    acc_in = acc_ff + (acc_ff[47] ? thwc_pkg::TRUNC_BIAS
                                                                  : 48'sd0);
            default:                acc_in = acc_ff;
         endcase
      end
   end

   // Final values of the two paths.
   assign temp_value  = $signed({1'b0, avg_ff}) - thwc_pkg::TEMP_OFFSET;
   assign quot        = acc_ff[47:24];
   assign humid_value = (quot > thwc_pkg::HUMID_MAX) ? 15'sd10000 : quot[14:0];

   // Classification, stored state and the response register.
   always_comb begin
      last_temp_in = last_temp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      for (int i = 0; i < 2; i++) begin
         temp_zone_in[i]  = temp_zone_ff[i];
         humid_zone_in[i] = humid_zone_ff[i];
         if (uop.fin == thwc_pkg::FIN_HUMID) begin
            new_zone[i] = thwc_pkg::thwc_classify(humid_zone_ff[i],
                                                  {3'b000, avg_ff},
                                                  {5'b00000, humid_low_ff[i]},
                                                  {5'b00000, humid_high_ff[i]},
                                                  thwc_pkg::HUMID_HYSTERESIS);
            zone_changed[i] = (new_zone[i] != humid_zone_ff[i]);
         end else begin
            new_zone[i] = thwc_pkg::thwc_classify(temp_zone_ff[i],
                                                  {{2{temp_value[14]}}, temp_value},
                                                  {{2{temp_low_ff[i][14]}}, temp_low_ff[i]},
                                                  {{2{temp_high_ff[i][14]}},
                                                   temp_high_ff[i]},
                                                  thwc_pkg::TEMP_HYSTERESIS);
            zone_changed[i] = (new_zone[i] != temp_zone_ff[i]);
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (advance && uop.fin != thwc_pkg::FIN_NONE) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.class_plant0   = new_zone[0];
         rsp_data_in.class_plant1   = new_zone[1];
         rsp_data_in.changed_plant0 = zone_changed[0];
         rsp_data_in.changed_plant1 = zone_changed[1];
         if (uop.fin == thwc_pkg::FIN_HUMID) begin
            rsp_data_in.measured_value = humid_value;
            humid_zone_in[0] = new_zone[0];
            humid_zone_in[1] = new_zone[1];
         end else begin
            rsp_data_in.measured_value = temp_value;
            last_temp_in     = temp_value;
            temp_zone_in[0]  = new_zone[0];
            temp_zone_in[1]  = new_zone[1];
         end
      end
   end

   // Threshold writes.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         temp_low_in[i]   = temp_low_ff[i];
         temp_high_in[i]  = temp_high_ff[i];
         humid_low_in[i]  = humid_low_ff[i];
         humid_high_in[i] = humid_high_ff[i];
      end
      if (csr_we) begin
         unique case (csr_index)
            thwc_pkg::CSR_TEMP_LOW0:   temp_low_in[0]   = csr_wdata;
            thwc_pkg::CSR_TEMP_LOW1:   temp_low_in[1]   = csr_wdata;
            thwc_pkg::CSR_TEMP_HIGH0:  temp_high_in[0]  = csr_wdata;
            thwc_pkg::CSR_TEMP_HIGH1:  temp_high_in[1]  = csr_wdata;
            thwc_pkg::CSR_HUMID_LOW0:  humid_low_in[0]  = csr_wdata[11:0];
            thwc_pkg::CSR_HUMID_LOW1:  humid_low_in[1]  = csr_wdata[11:0];
            thwc_pkg::CSR_HUMID_HIGH0: humid_high_in[0] = csr_wdata[11:0];
            thwc_pkg::CSR_HUMID_HIGH1: humid_high_in[1] = csr_wdata[11:0];
            default: begin
               temp_low_in[0] = temp_low_ff[0];
            end
         endcase
      end
   end

   // Control and architectural registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= thwc_pkg::SEQ_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         last_temp_ff <= thwc_pkg::LAST_TEMP_RESET;
         for (int i = 0; i < 2; i++) begin
            temp_zone_ff[i]  <= thwc_pkg::ZONE_OK;
            humid_zone_ff[i] <= thwc_pkg::ZONE_OK;
            temp_low_ff[i]   <= thwc_pkg::TEMP_LOW_RESET;
            temp_high_ff[i]  <= thwc_pkg::TEMP_HIGH_RESET;
            humid_low_ff[i]  <= thwc_pkg::HUMID_LOW_RESET;
            humid_high_ff[i] <= thwc_pkg::HUMID_HIGH_RESET;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         last_temp_ff <= last_temp_in;
         for (int i = 0; i < 2; i++) begin
            temp_zone_ff[i]  <= temp_zone_in[i];
            humid_zone_ff[i] <= humid_zone_in[i];
            temp_low_ff[i]   <= temp_low_in[i];
            temp_high_ff[i]  <= temp_high_in[i];
            humid_low_ff[i]  <= humid_low_in[i];
            humid_high_ff[i] <= humid_high_in[i];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      opcode_ff   <= opcode_in;
      sum_ff      <= sum_in;
      avg_ff      <= avg_in;
      prod_ff     <= prod_in;
      tmp_ff      <= tmp_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

@@ verif/tb_temp_humidity_window_classifier.sv @@
// Self-checking testbench of the temperature and humidity window classifier.
`default_nettype none
module tb_temp_humidity_window_classifier;

   // Hysteresis of the two classifier paths and the humidity coefficients;
   // the coefficients are scaled by 2^24 and rounded to nearest.
   localparam int     TEMP_HYST   = 100;
   localparam int     HUMID_HYST  = 50;
   localparam int     RAW_TO_CDEG = 3960;
   localparam int     CDEG_REF    = 2500;
   localparam int     HUMID_CAP   = 10000;
   localparam longint K_TEMP      = 64'sd167772;
   localparam longint K_TEMP_RAW  = 64'sd1342;
   localparam longint K_OFFSET    = 64'sd3433960571;
   localparam longint K_LINEAR    = 64'sd61572383;
   localparam longint K_SQUARE    = 64'sd2677;
   localparam longint K_SCALE     = 64'sd16777216;

   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int SETTLE_CYCLES   = 16;
   localparam int HOLD_CYCLES     = 300;
   localparam int HOLD_AFTER      = 125;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   thwc_pkg::thwc_req_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   thwc_pkg::thwc_rsp_type rsp_data;
   logic                   csr_we = 1'b0;
   logic [2:0]             csr_index = '0;
   logic [14:0]            csr_wdata = '0;

   temp_humidity_window_classifier u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The run must be over long before this; the slowest legal run needs well
   // under a fifth of it.
   initial begin
      #3_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Our own copy of the block's state: the thresholds as last written, the
   // last temperature in centidegrees and the zone of each plant on each path.
   int                 temp_lo [2];
   int                 temp_hi [2];
   int                 humid_lo [2];
   int                 humid_hi [2];
   int                 last_cdeg;
   thwc_pkg::zone_type temp_zone [2];
   thwc_pkg::zone_type humid_zone [2];

   // Responses we are still waiting for, oldest first.
   thwc_pkg::thwc_rsp_type expected_reports [$];
   int                     mismatch_count = 0;
   int                     reports_seen = 0;
   int                     burst_left = 0;

   // Directed rows. Where the outcome is plain from the rules (extremes, the
   // threshold edges at reset settings, the upper clamp) it is typed in;
   // the other rows are checked against the predictor.
   typedef struct {
      logic               op;
      int                 s1;
      int                 s2;
      int                 s3;
      bit                 typed;
      int                 value;
      thwc_pkg::zone_type c0;
      thwc_pkg::zone_type c1;
      bit                 ch0;
      bit                 ch1;
   } directed_row_type;

   directed_row_type directed_rows [25] = '{
      // Coldest and hottest readings, then truncation of the average.
      '{thwc_pkg::OP_TEMP,  0,     0,     0,     1'b1, -3960,
        thwc_pkg::ZONE_LOW,  thwc_pkg::ZONE_LOW,  1'b1, 1'b1},
      '{thwc_pkg::OP_TEMP,  16383, 16383, 16383, 1'b1, 12423,
        thwc_pkg::ZONE_HIGH, thwc_pkg::ZONE_HIGH, 1'b1, 1'b1},
      '{thwc_pkg::OP_TEMP,  16383, 16383, 16382, 1'b1, 12422,
        thwc_pkg::ZONE_HIGH, thwc_pkg::ZONE_HIGH, 1'b0, 1'b0},
      // Walk the temperature window edges with the reset thresholds.
      '{thwc_pkg::OP_TEMP,  5460,  5460,  5460,  1'b1, 1500,
        thwc_pkg::ZONE_HIGH, thwc_pkg::ZONE_HIGH, 1'b0, 1'b0},
      '{thwc_pkg::OP_TEMP,  5560,  5560,  5560,  1'b1, 1600,
        thwc_pkg::ZONE_OK,   thwc_pkg::ZONE_OK,   1'b1, 1'b1},
      '{thwc_pkg::OP_TEMP,  5459,  5459,  5459,  1'b1, 1499,
        thwc_pkg::ZONE_LOW,  thwc_pkg::ZONE_LOW,  1'b1, 1'b1},
      '{thwc_pkg::OP_TEMP,  5559,  5559,  5559,  1'b1, 1599,
        thwc_pkg::ZONE_LOW,  thwc_pkg::ZONE_LOW,  1'b0, 1'b0},
      '{thwc_pkg::OP_TEMP,  6960,  6960,  6960,  1'b1, 3000,
        thwc_pkg::ZONE_LOW,  thwc_pkg::ZONE_LOW,  1'b0, 1'b0},
      '{thwc_pkg::OP_TEMP,  6961,  6961,  6961,  1'b1, 3001,
        thwc_pkg::ZONE_HIGH, thwc_pkg::ZONE_HIGH, 1'b1, 1'b1},
      '{thwc_pkg::OP_TEMP,  6860,  6860,  6860,  1'b1, 2900,
        thwc_pkg::ZONE_OK,   thwc_pkg::ZONE_OK,   1'b1, 1'b1},
      '{thwc_pkg::OP_TEMP,  6460,  6460,  6460,  1'b1, 2500,
        thwc_pkg::ZONE_OK,   thwc_pkg::ZONE_OK,   1'b0, 1'b0},
      // Humidity at the reference temperature: the top reading hits the clamp.
      '{thwc_pkg::OP_HUMID, 16383, 16383, 16383, 1'b1, 10000,
        thwc_pkg::ZONE_HIGH, thwc_pkg::ZONE_HIGH, 1'b1, 1'b1},
      '{thwc_pkg::OP_HUMID, 0,     0,     0,     1'b0, 0,
        thwc_pkg::ZONE_OK,   thwc_pkg::ZONE_OK,   1'b0, 1'b0},
      '{thwc_pkg::OP_HUMID, 1000,  1000,  1000,  1'b0, 0,
        thwc_pkg::ZONE_OK,   thwc_pkg::ZONE_OK,   1'b0, 1'b0},
      '{thwc_pkg::OP_HUMID, 1050,  1050,  1050,  1'b0, 0,
        thwc_pkg::ZONE_OK,   thwc_pkg::ZONE_OK,   1'b0, 1'b0},
      '{thwc_pkg::OP_HUMID, 999,   999,   999,   1'b0, 0,
        thwc_pkg::ZONE_OK,   thwc_pkg::ZONE_OK,   1'b0, 1'b0},
      '{thwc_pkg::OP_HUMID, 3001,  3001,  3001,  1'b0, 0,
        thwc_pkg::ZONE_OK,   thwc_pkg::ZONE_OK,   1'b0, 1'b0},
      '{thwc_pkg::OP_HUMID, 2950,  2950,  2950,  1'b0, 0,
        thwc_pkg::ZONE_OK,   thwc_pkg::ZONE_OK,   1'b0, 1'b0},
      '{thwc_pkg::OP_HUMID, 4095,  0,     0,     1'b0, 0,
        thwc_pkg::ZONE_OK,   thwc_pkg::ZONE_OK,   1'b0, 1'b0},
      '{thwc_pkg::OP_HUMID, 1,     1,     0,     1'b0, 0,
        thwc_pkg::ZONE_OK,   thwc_pkg::ZONE_OK,   1'b0, 1'b0},
      // Coldest stored temperature, then humidity at the top of and above the 12-bit range.
      '{thwc_pkg::OP_TEMP,  0,     0,     1,     1'b0, 0,
        thwc_pkg::ZONE_OK,   thwc_pkg::ZONE_OK,   1'b0, 1'b0},
      '{thwc_pkg::OP_HUMID, 4095,  4095,  4095,  1'b0, 0,
        thwc_pkg::ZONE_OK,   thwc_pkg::ZONE_OK,   1'b0, 1'b0},
      '{thwc_pkg::OP_HUMID, 16383, 0,     0,     1'b0, 0,
        thwc_pkg::ZONE_OK,   thwc_pkg::ZONE_OK,   1'b0, 1'b0},
      // Alternating bit patterns in the samples.
      '{thwc_pkg::OP_TEMP,  10922, 5461,  16383, 1'b0, 0,
        thwc_pkg::ZONE_OK,   thwc_pkg::ZONE_OK,   1'b0, 1'b0},
      '{thwc_pkg::OP_HUMID, 5461,  10922, 0,     1'b0, 0,
        thwc_pkg::ZONE_OK,   thwc_pkg::ZONE_OK,   1'b0, 1'b0}
   };

   // Clips a wanted raw reading into the 14-bit converter range.
   function automatic logic [13:0] to_sample(input int v);
      if (v < 0) begin
         return 14'd0;
      end
      if (v > 16383) begin
         return 14'd16383;
      end
      return v[13:0];
   endfunction

   // Low/ok/high decision with hysteresis only on the way back to ok.
   function automatic thwc_pkg::zone_type next_zone(input thwc_pkg::zone_type cur,
                                                    input int v, input int lo,
                                                    input int hi, input int hyst);
      if (cur != thwc_pkg::ZONE_LOW && v < lo) begin
         return thwc_pkg::ZONE_LOW;
      end
      if (cur != thwc_pkg::ZONE_HIGH && v > hi) begin
         return thwc_pkg::ZONE_HIGH;
      end
      if (cur != thwc_pkg::ZONE_OK && v >= lo + hyst && v <= hi - hyst) begin
         return thwc_pkg::ZONE_OK;
      end
      return cur;
   endfunction

   // Computes the response to one request and advances our copy of the state.
   task automatic evaluate_reading(input thwc_pkg::thwc_req_type r,
                                   output thwc_pkg::thwc_rsp_type rep);
      int                 avg;
      int                 value;
      longint             raw;
      longint             acc;
      longint             quot;
      thwc_pkg::zone_type old0;
      thwc_pkg::zone_type old1;
      avg = (int'(r.sample_first) + int'(r.sample_second) + int'(r.sample_third)) / 3;
      if (r.opcode == thwc_pkg::OP_TEMP) begin
         value = avg - RAW_TO_CDEG;
         last_cdeg = value;
         old0 = temp_zone[0];
         old1 = temp_zone[1];
         temp_zone[0] = next_zone(old0, value, temp_lo[0], temp_hi[0], TEMP_HYST);
         temp_zone[1] = next_zone(old1, value, temp_lo[1], temp_hi[1], TEMP_HYST);
         rep.class_plant0 = temp_zone[0];
         rep.class_plant1 = temp_zone[1];
      end else begin
         // Relative humidity in hundredths of a percent, compensated with the
         // last temperature. Signed division truncates toward zero.
         raw = longint'(avg);
         acc = (longint'(last_cdeg) - CDEG_REF) * (K_TEMP + K_TEMP_RAW * raw)
               - K_OFFSET + K_LINEAR * raw - K_SQUARE * raw * raw;
         quot = acc / K_SCALE;
         if (quot > HUMID_CAP) begin
            quot = HUMID_CAP;
         end
         value = int'(quot);
         old0 = humid_zone[0];
         old1 = humid_zone[1];
         humid_zone[0] = next_zone(old0, avg, humid_lo[0], humid_hi[0], HUMID_HYST);
         humid_zone[1] = next_zone(old1, avg, humid_lo[1], humid_hi[1], HUMID_HYST);
         rep.class_plant0 = humid_zone[0];
         rep.class_plant1 = humid_zone[1];
      end
      rep.measured_value = value[14:0];
      rep.changed_plant0 = (thwc_pkg::zone_type'(rep.class_plant0) != old0);
      rep.changed_plant1 = (thwc_pkg::zone_type'(rep.class_plant1) != old1);
   endtask

   // Writes one threshold register and mirrors it into our copy. Temperature
   // thresholds are 15-bit signed; humidity ones keep only the low 12 bits.
   task automatic write_csr(input logic [2:0] idx, input logic [14:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      unique case (idx)
         thwc_pkg::CSR_TEMP_LOW0:   temp_lo[0]  = int'($signed(data));
         thwc_pkg::CSR_TEMP_LOW1:   temp_lo[1]  = int'($signed(data));
         thwc_pkg::CSR_TEMP_HIGH0:  temp_hi[0]  = int'($signed(data));
         thwc_pkg::CSR_TEMP_HIGH1:  temp_hi[1]  = int'($signed(data));
         thwc_pkg::CSR_HUMID_LOW0:  humid_lo[0] = int'(data[11:0]);
         thwc_pkg::CSR_HUMID_LOW1:  humid_lo[1] = int'(data[11:0]);
         thwc_pkg::CSR_HUMID_HIGH0: humid_hi[0] = int'(data[11:0]);
         thwc_pkg::CSR_HUMID_HIGH1: humid_hi[1] = int'(data[11:0]);
         default: begin
         end
      endcase
   endtask

   // Offers one request and returns at the edge where it is accepted. The
   // sender runs in bursts; between bursts valid may drop for a random gap.
   task automatic offer_request(input thwc_pkg::thwc_req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   // Response side. Every edge it checks a handshake against the oldest
   // expectation, then picks the next value of ready. The stall pattern
   // changes mode after each segment of random length; once, early in the
   // random traffic, it holds ready low for a long stretch so the block backs
   // up into the request side.
   initial begin : response_side
      thwc_pkg::thwc_rsp_type want;
      int                     mode;
      int                     seg_left;
      int                     hold_left;
      bit                     hold_done;
      logic                   ready_next;
      mode      = 0;
      seg_left  = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
               $error("response with no request outstanding: measured_value %0d",
                      rsp_data.measured_value);
               mismatch_count++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_data.measured_value !== want.measured_value) begin
                  $error("measured_value: expected %0d, actual %0d",
                         want.measured_value, rsp_data.measured_value);
                  mismatch_count++;
               end
               if (rsp_data.class_plant0 !== want.class_plant0) begin
                  $error("class_plant0: expected %0d, actual %0d",
                         want.class_plant0, rsp_data.class_plant0);
                  mismatch_count++;
               end
               if (rsp_data.class_plant1 !== want.class_plant1) begin
                  $error("class_plant1: expected %0d, actual %0d",
                         want.class_plant1, rsp_data.class_plant1);
                  mismatch_count++;
               end
               if (rsp_data.changed_plant0 !== want.changed_plant0) begin
                  $error("changed_plant0: expected %0d, actual %0d",
                         want.changed_plant0, rsp_data.changed_plant0);
                  mismatch_count++;
               end
               if (rsp_data.changed_plant1 !== want.changed_plant1) begin
                  $error("changed_plant1: expected %0d, actual %0d",
                         want.changed_plant1, rsp_data.changed_plant1);
                  mismatch_count++;
               end
            end
         end

         if (!hold_done && reports_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end

         if (seg_left == 0) begin
            mode     = $urandom_range(0, 3);
            seg_left = $urandom_range(10, 60);
         end
         seg_left--;

         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            unique case (mode)
               0:       ready_next = 1'b1;
               1:       ready_next = 1'($urandom_range(0, 1));
               2:       ready_next = ($urandom_range(0, 3) == 0);
               default: ready_next = ($urandom_range(0, 7) != 0);
            endcase
         end
         rsp_ready <= ready_next;
      end
   end

   // Request side: reset, the directed rows, then phases of random traffic
   // with a fresh set of thresholds before each phase after the first.
   initial begin : request_side
      thwc_pkg::thwc_req_type item;
      thwc_pkg::thwc_rsp_type rep;
      int                     pick;
      int                     plant;
      int                     base;
      int                     spread;
      int                     target;
      int                     t_lo [2];
      int                     t_hi [2];
      int                     h_lo [2];
      int                     h_hi [2];

      for (int p = 0; p < 2; p++) begin
         temp_lo[p]    = 1500;
         temp_hi[p]    = 3000;
         humid_lo[p]   = 1000;
         humid_hi[p]   = 3000;
         temp_zone[p]  = thwc_pkg::ZONE_OK;
         humid_zone[p] = thwc_pkg::ZONE_OK;
      end
      last_cdeg = 2000;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         item.opcode        = directed_rows[i].op;
         item.sample_first  = directed_rows[i].s1[13:0];
         item.sample_second = directed_rows[i].s2[13:0];
         item.sample_third  = directed_rows[i].s3[13:0];
         offer_request(item);
         evaluate_reading(item, rep);
         if (directed_rows[i].typed) begin
            rep.measured_value = directed_rows[i].value[14:0];
            rep.class_plant0   = directed_rows[i].c0;
            rep.class_plant1   = directed_rows[i].c1;
            rep.changed_plant0 = directed_rows[i].ch0;
            rep.changed_plant1 = directed_rows[i].ch1;
         end
         expected_reports.push_back(rep);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            // Thresholds change only with the block idle: every response in,
            // then a settling pause longer than a humidity request takes.
            req_valid <= 1'b0;
            wait (expected_reports.size() == 0);
            repeat (SETTLE_CYCLES) @(posedge clock);
            unique case (phase)
               2: begin
                  // Ends of the value ranges; plant 1 gets its window inverted.
                  t_lo = '{-3960, 12423};
                  t_hi = '{12423, -3960};
                  h_lo = '{0, 4095};
                  h_hi = '{4095, 0};
               end
               3: begin
                  // Windows narrower than twice the hysteresis never reach ok again.
                  t_lo = '{2000, 2500};
                  t_hi = '{2150, 2400};
                  h_lo = '{2000, 1200};
                  h_hi = '{2080, 1100};
               end
               4: begin
                  // Full width of the register: every data bit at both values.
                  t_lo = '{-16384, -16384};
                  t_hi = '{16383, 16383};
                  h_lo = '{0, 0};
                  h_hi = '{4095, 4095};
               end
               default: begin
                  for (int p = 0; p < 2; p++) begin
                     t_lo[p] = -3960 + int'($urandom_range(0, 8000));
                     t_hi[p] = t_lo[p] + int'($urandom_range(0, 6000));
                     h_lo[p] = $urandom_range(0, 2500);
                     h_hi[p] = h_lo[p] + int'($urandom_range(0, 1500));
                  end
               end
            endcase
            // Humidity registers carry junk in the unused upper bits.
            write_csr(thwc_pkg::CSR_TEMP_LOW0,   t_lo[0][14:0]);
            write_csr(thwc_pkg::CSR_TEMP_LOW1,   t_lo[1][14:0]);
            write_csr(thwc_pkg::CSR_TEMP_HIGH0,  t_hi[0][14:0]);
            write_csr(thwc_pkg::CSR_TEMP_HIGH1,  t_hi[1][14:0]);
            write_csr(thwc_pkg::CSR_HUMID_LOW0,  {3'($urandom_range(0, 7)), h_lo[0][11:0]});
            write_csr(thwc_pkg::CSR_HUMID_LOW1,  {3'($urandom_range(0, 7)), h_lo[1][11:0]});
            write_csr(thwc_pkg::CSR_HUMID_HIGH0, {3'($urandom_range(0, 7)), h_hi[0][11:0]});
            write_csr(thwc_pkg::CSR_HUMID_HIGH1, {3'($urandom_range(0, 7)), h_hi[1][11:0]});
            csr_we <= 1'b0;
         end

         repeat (ITEMS_PER_PHASE) begin
            item.opcode = $urandom_range(0, 1) ? thwc_pkg::OP_HUMID : thwc_pkg::OP_TEMP;
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               // Noise over the whole converter range, or the 12-bit range
               // that humidity normally uses.
               spread = (item.opcode == thwc_pkg::OP_HUMID && pick < 6) ? 4095 : 16383;
               item.sample_first  = 14'($urandom_range(0, spread));
               item.sample_second = 14'($urandom_range(0, spread));
               item.sample_third  = 14'($urandom_range(0, spread));
            end else if (pick < 23) begin
               // Corner readings mixed per sample.
               item.sample_first  = to_sample(($urandom_range(0, 1)) ? 16383 : 0);
               item.sample_second = ($urandom_range(0, 1)) ? 14'd4095 : 14'd16383;
               item.sample_third  = ($urandom_range(0, 1)) ? 14'd0 : 14'd8191;
            end else begin
               // Most requests aim just around a threshold of either plant so
               // the zones keep moving and the hysteresis band gets crossed.
               plant = $urandom_range(0, 1);
               if (item.opcode == thwc_pkg::OP_TEMP) begin
                  base   = ($urandom_range(0, 1) ? temp_hi[plant] : temp_lo[plant])
                           + RAW_TO_CDEG;
                  spread = TEMP_HYST + 30;
               end else begin
                  base   = $urandom_range(0, 1) ? humid_hi[plant] : humid_lo[plant];
                  spread = HUMID_HYST + 30;
               end
               target = base + int'($urandom_range(0, 2 * spread)) - spread;
               item.sample_first  = to_sample(target + int'($urandom_range(0, 6)) - 3);
               item.sample_second = to_sample(target + int'($urandom_range(0, 6)) - 3);
               item.sample_third  = to_sample(3 * target - int'(item.sample_first)
                                              - int'(item.sample_second));
            end
            offer_request(item);
            evaluate_reading(item, rep);
            expected_reports.push_back(rep);
         end
      end

      // Drain: every response in, then a pause for strays.
      req_valid <= 1'b0;
      wait (expected_reports.size() == 0);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ files.f @@
sv/thwc_pkg.sv
sv/temp_humidity_window_classifier.sv
verif/tb_temp_humidity_window_classifier.sv
